// File: rtl/byte_substring_detector_assert.svh
// Assertion macros for the byte substring detector.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef BYTE_SUBSTRING_DETECTOR_ASSERT_SVH
`define BYTE_SUBSTRING_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bsd_pkg.sv
// Shared types, constants and helpers for the byte substring detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bsd_pkg;

    localparam int PAT_BYTES  = 16;   // needle bytes held in the registers
    localparam int LEN_W      = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    localparam int DEF_MAX_PATTERN = 16;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [PAT_BYTES*8-1:0] pattern;
        logic [LEN_W-1:0]       length;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] needle_byte(input logic [PAT_BYTES*8-1:0] pattern,
                                               input logic [3:0] idx);
        needle_byte = pattern[idx*8 +: 8];
    endfunction

endpackage

// File: rtl/bsd_front.sv
// Front end: registers each accepted byte and tags it as mid-stream or last.
// Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    input  logic          is_final,
    output logic          item_valid,
    input  logic          item_ready,
    output bsd_pkg::item_t item
);
    import bsd_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Holding stage frees up whenever the queue takes its item.
    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.data <= data_byte;
            item_reg.last <= is_final;
        end
    end

endmodule

// File: rtl/bsd_queue.sv
// Short FIFO between front and back ends.
// Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_queue #(
    parameter int DEPTH = bsd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  bsd_pkg::item_t     push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output bsd_pkg::item_t     pop_item,
    output bsd_pkg::q_status_t status
);
    import bsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign push_ready   = !status.full;
    assign pop_valid    = !status.empty;
    assign pop_item     = mem[rd_ptr_reg];
    assign push         = push_valid && push_ready;
    assign pop          = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/bsd_back.sv
// Back end: byte window, parallel needle compare, sticky match and result register.
// Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_back #(
    parameter int MAX_PATTERN = bsd_pkg::DEF_MAX_PATTERN
) (
    input  logic           clk,
    input  logic           rst_n,
    input  bsd_pkg::cfg_t  cfg,
    input  logic           item_valid,
    output logic           item_ready,
    input  bsd_pkg::item_t item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           found
);
    import bsd_pkg::*;

    localparam int WIN_D  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int CMP_N  = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
    localparam int SEEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CW     = ((SEEN_W > LEN_W) ? SEEN_W : LEN_W) + 1;

    logic [7:0]        recent_reg [WIN_D];
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic              match_seen_reg, match_seen_next;
    logic              out_valid_reg, found_reg;
    logic              match_now, bytes_ok, len_ok;
    logic              pop;
    logic [LEN_W-1:0]  idx;

    // A final byte needs the result register free; other bytes always go.
    assign item_ready = !item.last || !out_valid_reg || out_ready;
    assign pop        = item_valid && item_ready;
    assign out_valid  = out_valid_reg;
    assign found      = found_reg;

    always_comb
    begin
        len_ok   = (cfg.length != '0) && (cfg.length <= LEN_W'(CMP_N));
        bytes_ok = (CW'(seen_reg) + CW'(1)) >= CW'(cfg.length);
        idx      = cfg.length - 1'b1;
        match_now = len_ok && bytes_ok &&
                    (needle_byte(cfg.pattern, idx[3:0]) == item.data);
        for (int k = 1; k < CMP_N; k++)
        begin
            idx = cfg.length - LEN_W'(k) - 1'b1;
            if ((LEN_W'(k) < cfg.length) &&
                (needle_byte(cfg.pattern, idx[3:0]) != recent_reg[k-1]))
            begin
                match_now = 1'b0;
            end
        end
    end

    always_comb
    begin
        seen_next       = seen_reg;
        match_seen_next = match_seen_reg;
        if (pop)
        begin
            if (item.last)
            begin
                seen_next       = '0;
                match_seen_next = 1'b0;
            end
            else
            begin
                match_seen_next = match_seen_reg || match_now;
                if (seen_reg != SEEN_W'(MAX_PATTERN))
                begin
                    seen_next = seen_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            match_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            seen_reg       <= seen_next;
            match_seen_reg <= match_seen_next;
            if (pop && item.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && item.last)
        begin
            found_reg <= match_seen_reg || match_now;
        end
    end

    // Window of earlier bytes, newest in entry 0; entries past the byte count
    // are never compared, so no clear is needed.
    generate
        if (MAX_PATTERN > 1)
        begin : g_window
            always_ff @(posedge clk)
            begin
                if (pop && !item.last)
                begin
                    recent_reg[0] <= item.data;
                    for (int i = 1; i < WIN_D; i++)
                    begin
                        recent_reg[i] <= recent_reg[i-1];
                    end
                end
            end
        end
        else
        begin : g_no_window
            always_ff @(posedge clk)
            begin
                recent_reg[0] <= 8'h00;
            end
        end
    endgenerate

endmodule

// File: rtl/byte_substring_detector.sv
// Top level of the streaming byte substring detector.
// Depends on bsd_pkg, bsd_front, bsd_queue, bsd_back and the assertion header.
`timescale 1ns / 1ps

// Haystack bytes arrive one item per cycle on in_valid/in_ready while
// in_ready is high, with is_final set on the last byte of a search. The
// needle (up to 16 bytes, byte 0 in bits 7:0 of pattern_low_reg) and its
// length must be written through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this. Index 0 is the
// low eight needle bytes, 1 the high eight, 2 the length (cfg_data[4:0]).
// Exactly one result item comes out per final byte: found is 1 when the
// needle occurred anywhere in that haystack. A zero length, a length above
// 16 or above MAX_PATTERN, or a haystack shorter than the needle all give 0.
// Sustained rate is one byte per cycle while the output is not stalled:
// each byte is compared against the whole needle combinationally by a
// parallel byte-equality check in the back end. After the final byte is
// accepted it passes through the front holding register and a queue entry
// before the result register loads and out_valid rises. A stalled output
// blocks only final items; the queue of QUEUE_DEPTH items lets the front
// keep taking bytes meanwhile. Stream state clears itself after each final
// byte; the needle registers keep their values.

module byte_substring_detector #(
    parameter int MAX_PATTERN = bsd_pkg::DEF_MAX_PATTERN,
    parameter int QUEUE_DEPTH = bsd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data,
    // haystack input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           is_final,
    // result output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found
);
    import bsd_pkg::*;

    `include "byte_substring_detector_assert.svh"

    // Needle registers
    logic [63:0]      pattern_low_reg;
    logic [63:0]      pattern_high_reg;
    logic [LEN_W-1:0] pattern_len_reg;
    cfg_t             cfg;

    // Front to queue
    logic      fr_valid, fr_ready;
    item_t     fr_item;
    // Queue to back
    logic      q_valid, q_ready;
    item_t     q_item;
    q_status_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            pattern_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[LEN_W-1:0];
                default:          ; // unused index: write is dropped
            endcase
        end
    end

    assign cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign cfg.length  = pattern_len_reg;

    bsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .is_final   (is_final),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    bsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item),
        .status     (q_stat)
    );

    bsd_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found)
    );

    // A new result only ever follows a final item leaving the queue.
    `BSD_ASSERT_NOW(a_result_from_final, $rose(out_valid), $past(q_valid && q_ready && q_item.last), "result without a final item")
    // Input stalls only when the front holds an item the queue cannot take.
    `BSD_ASSERT_NOW(a_stall_cause, !in_ready, fr_valid && q_stat.full, "input stalled with room to spare")
    // Queue cannot be full and empty at once.
    `BSD_ASSERT_NOW(a_queue_count, q_stat.full, !q_stat.empty, "queue full and empty together")
    // An unread result is held until taken.
    `BSD_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(found), "result dropped while stalled")

endmodule
